/* hw/rtl/pta_pkg.sv */
// Shared types and constants for the peer table with aging.
// No dependencies; used by peer_table_with_aging.
package pta_pkg;

  localparam int unsigned IdW        = 256;
  localparam int unsigned TimeW      = 32;
  localparam int unsigned DbmW       = 8;
  localparam int unsigned BestW      = 11;
  localparam int unsigned PeerCountW = 9;
  localparam int unsigned InDataW    = 296;
  localparam int unsigned OutDataW   = 24;

  localparam logic signed [BestW-1:0] NoPeerDbm = -11'sd1000;
  localparam logic [TimeW-1:0] DefaultAwayMs    = 32'd120000;

  // operation codes carried on tuser
  typedef enum logic {
    OpSighting = 1'b0,
    OpSweep    = 1'b1
  } op_e;

  // sequencer states
  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StDrain,
    StWrap,
    StPut
  } state_e;

  // per-entry bookkeeping kept beside the identity
  typedef struct packed {
    logic                   gone;
    logic signed [DbmW-1:0] strength;
    logic [TimeW-1:0]       last_seen;
  } meta_t;

endpackage

/* hw/rtl/pta_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module pta_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/peer_table_with_aging.sv */
// Top level of the peer table with aging: sequencer, shared entry evaluator, result register.
// Depends on pta_pkg and pta_ram.
//
//  channel   | direction | handshake                 | payload
//  s_axis    | in        | tvalid/tready             | tuser: operation; tdata: now, id, dbm
//  m_axis    | out       | tvalid/tready             | tdata: closest, count, new, full
//  cfg       | in        | cfg_we_i, no wait         | away threshold in ms
//
// The table RAMs are read one entry per cycle and each entry passes the one evaluator.
// No clearing pass after reset; only entries below the count are ever read.
// The input is not ready during a scan. A waiting result sits in the output register
// while the next request is scanned; a scan that finishes before it is taken holds.
module peer_table_with_aging #(
  parameter int unsigned MAX_PEERS = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // tdata: now_ms[31:0], identity_word0..3[287:32], signal_dbm[295:288]
  input  logic [pta_pkg::InDataW-1:0]   s_axis_tdata_i,
  // tuser: operation
  input  logic                          s_axis_tuser_i,
  // result stream
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // tdata: closest_dbm[10:0], peer_count[19:11], new_peer[20], table_full[21], zero[23:22]
  output logic [pta_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // threshold register
  input  logic                          cfg_we_i,
  input  logic [pta_pkg::TimeW-1:0]     cfg_wdata_i
);

  localparam int unsigned AddrW  = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
  localparam int unsigned CountW = $clog2(MAX_PEERS + 1);
  localparam int unsigned MetaW  = $bits(pta_pkg::meta_t);
  localparam logic [CountW-1:0] MaxCount = CountW'(MAX_PEERS);

  pta_pkg::state_e state_q, state_d;

  logic [pta_pkg::TimeW-1:0] thr_q;
  logic [CountW-1:0]         cnt_q, cnt_d;
  logic [AddrW-1:0]          idx_q, idx_d;
  logic                      pv_q, pv_d;
  logic [AddrW-1:0]          paddr_q, paddr_d;
  logic                      hit_q, hit_d;
  logic signed [pta_pkg::BestW-1:0] best_q, best_d;

  // latched request
  pta_pkg::op_e                     op_q;
  logic [pta_pkg::TimeW-1:0]        now_q;
  logic [pta_pkg::IdW-1:0]          id_q;
  logic signed [pta_pkg::DbmW-1:0]  dbm_q;
  logic                             load_req;

  // result register
  logic                           out_v_q, out_v_d;
  logic [pta_pkg::OutDataW-1:0]   out_q, out_d;
  logic                           res_load;

  // RAM ports
  logic                   id_we;
  logic [AddrW-1:0]       id_waddr;
  logic                   meta_we;
  logic [AddrW-1:0]       meta_waddr;
  pta_pkg::meta_t         meta_wdata;
  logic                   rd_en;
  logic [pta_pkg::IdW-1:0] rd_id;
  logic [MetaW-1:0]       rd_meta_raw;
  pta_pkg::meta_t         rd_meta;

  // evaluator signals
  logic                   match;
  logic [pta_pkg::TimeW-1:0] age;
  logic                   gone_new;
  logic                   cand_gone;
  logic signed [pta_pkg::DbmW-1:0] cand_dbm;
  logic signed [pta_pkg::BestW-1:0] cand_ext;
  logic signed [pta_pkg::BestW-1:0] dbm_ext;
  logic                   append;
  logic                   full;
  logic signed [pta_pkg::BestW-1:0] best_fin;
  logic [CountW-1:0]      cnt_fin;

  pta_ram #(.Width(pta_pkg::IdW), .Depth(MAX_PEERS)) u_id_ram (
    .clk_i   (clk_i),
    .we_i    (id_we),
    .waddr_i (id_waddr),
    .wdata_i (id_q),
    .re_i    (rd_en),
    .raddr_i (idx_q),
    .rdata_o (rd_id)
  );

  pta_ram #(.Width(MetaW), .Depth(MAX_PEERS)) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wdata),
    .re_i    (rd_en),
    .raddr_i (idx_q),
    .rdata_o (rd_meta_raw)
  );

  assign rd_meta = pta_pkg::meta_t'(rd_meta_raw);

  // shared evaluator: one entry per cycle
  assign match    = (op_q == pta_pkg::OpSighting) && !hit_q && (rd_id == id_q);
  assign age      = now_q - rd_meta.last_seen;
  assign gone_new = rd_meta.gone || (age > thr_q);
  always_comb begin
    if (op_q == pta_pkg::OpSweep) begin
      cand_gone = gone_new;
      cand_dbm  = rd_meta.strength;
    end else if (match) begin
      cand_gone = 1'b0;
      cand_dbm  = dbm_q;
    end else begin
      cand_gone = rd_meta.gone;
      cand_dbm  = rd_meta.strength;
    end
  end
  assign cand_ext = pta_pkg::BestW'(cand_dbm);
  assign dbm_ext  = pta_pkg::BestW'(dbm_q);

  // append decision at the end of a sighting scan
  assign append   = (op_q == pta_pkg::OpSighting) && !hit_q && (cnt_q < MaxCount);
  assign full     = (op_q == pta_pkg::OpSighting) && !hit_q && (cnt_q == MaxCount);
  assign best_fin = (append && (dbm_ext > best_q)) ? dbm_ext : best_q;
  assign cnt_fin  = append ? cnt_q + CountW'(1) : cnt_q;

  assign s_axis_tready_o = (state_q == pta_pkg::StIdle);
  assign load_req        = s_axis_tvalid_i && s_axis_tready_o;
  assign rd_en           = (state_q == pta_pkg::StScan);
  assign id_we           = (state_q == pta_pkg::StWrap) && append;
  assign id_waddr        = cnt_q[AddrW-1:0];

  // sequencer and evaluator updates
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    pv_d       = 1'b0;
    paddr_d    = idx_q;
    hit_d      = hit_q;
    best_d     = best_q;
    cnt_d      = cnt_q;
    meta_we    = 1'b0;
    meta_waddr = paddr_q;
    meta_wdata = '{gone: 1'b0, strength: dbm_q, last_seen: now_q};
    res_load   = 1'b0;

    // evaluate the entry read last cycle
    if (pv_q) begin
      if (!cand_gone && (cand_ext > best_q)) begin
        best_d = cand_ext;
      end
      if (match) begin
        hit_d   = 1'b1;
        meta_we = 1'b1;
      end else if (op_q == pta_pkg::OpSweep && gone_new && !rd_meta.gone) begin
        meta_we    = 1'b1;
        meta_wdata = '{gone: 1'b1, strength: rd_meta.strength,
                       last_seen: rd_meta.last_seen};
      end
    end

    case (state_q)
      pta_pkg::StIdle: begin
        if (load_req) begin
          idx_d   = '0;
          hit_d   = 1'b0;
          best_d  = pta_pkg::NoPeerDbm;
          state_d = (cnt_q == '0) ? pta_pkg::StWrap : pta_pkg::StScan;
        end
      end
      pta_pkg::StScan: begin
        pv_d    = 1'b1;
        paddr_d = idx_q;
        if (CountW'(idx_q) == cnt_q - CountW'(1)) begin
          state_d = pta_pkg::StDrain;
        end else begin
          idx_d = idx_q + AddrW'(1);
        end
      end
      pta_pkg::StDrain: begin
        state_d = pta_pkg::StWrap;
      end
      pta_pkg::StWrap: begin
        if (append) begin
          meta_we    = 1'b1;
          meta_waddr = cnt_q[AddrW-1:0];
        end
        cnt_d   = cnt_fin;
        best_d  = best_fin;
        state_d = pta_pkg::StPut;
      end
      pta_pkg::StPut: begin
        if (!out_v_q || m_axis_tready_i) begin
          res_load = 1'b1;
          state_d  = pta_pkg::StIdle;
        end
      end
      default: begin
        state_d = pta_pkg::StIdle;
      end
    endcase
  end

  // result assembly; the new and full flags are captured in the wrap cycle, from the final
  // hit_q and from cnt before it is updated there
  logic new_flag_q, full_flag_q;
  logic new_flag_d, full_flag_d;
  assign new_flag_d  = (state_q == pta_pkg::StWrap) ? append : new_flag_q;
  assign full_flag_d = (state_q == pta_pkg::StWrap) ? full : full_flag_q;

  always_comb begin
    out_d   = out_q;
    out_v_d = out_v_q;
    if (m_axis_tready_i) begin
      out_v_d = 1'b0;
    end
    if (res_load) begin
      out_v_d = 1'b1;
      out_d   = {2'b00, full_flag_q, new_flag_q,
                 pta_pkg::PeerCountW'(cnt_q), best_q};
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pta_pkg::StIdle;
      thr_q   <= pta_pkg::DefaultAwayMs;
      cnt_q   <= '0;
      pv_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pv_q    <= pv_d;
      out_v_q <= out_v_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    paddr_q     <= paddr_d;
    hit_q       <= hit_d;
    best_q      <= best_d;
    out_q       <= out_d;
    new_flag_q  <= new_flag_d;
    full_flag_q <= full_flag_d;
    if (load_req) begin
      op_q  <= pta_pkg::op_e'(s_axis_tuser_i);
      now_q <= s_axis_tdata_i[31:0];
      id_q  <= s_axis_tdata_i[287:32];
      dbm_q <= s_axis_tdata_i[295:288];
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_q;

endmodule
